[design/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared constants and types for the UTF-8 to 16-bit code unit decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [7:0] ASCII_LIMIT   = 8'h80;
  localparam logic [7:0] THREE_BYTE_AT = 8'hE0;
  localparam logic [7:0] LEAD2_MASK    = 8'h1F;
  localparam logic [7:0] LEAD3_MASK    = 8'h0F;
  localparam logic [7:0] CONT_MASK     = 8'h3F;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0]  pending;
    logic [15:0] partial;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] code_unit;
    logic        incomplete;
    logic        last_result;
  } dec_result_t;

endpackage

[design/u8u16_dec_core.sv]
// ----------------------------------------------------------------------------
// u8u16_dec_core
// Next-state and result logic for one UTF-8 byte against the current state.
// ----------------------------------------------------------------------------
module u8u16_dec_core (
  input  logic [7:0]             in_byte_i,
  input  logic                   string_end_i,
  input  u8u16_pkg::dec_state_t  state_i,
  output u8u16_pkg::dec_state_t  state_o,
  output u8u16_pkg::dec_result_t result_o
);

  logic [15:0] shifted;
  logic [7:0]  cont_bits;

  assign cont_bits = in_byte_i & u8u16_pkg::CONT_MASK;
  assign shifted   = {state_i.partial[9:0], cont_bits[5:0]};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.pending == u8u16_pkg::PEND_NONE) begin
      if (in_byte_i < u8u16_pkg::ASCII_LIMIT) begin
        result_o.valid       = 1'b1;
        result_o.code_unit   = {8'h00, in_byte_i};
        result_o.last_result = string_end_i;
      end else if (in_byte_i < u8u16_pkg::THREE_BYTE_AT) begin
        state_o.partial = {8'h00, in_byte_i & u8u16_pkg::LEAD2_MASK};
        state_o.pending = u8u16_pkg::PEND_ONE;
      end else begin
        state_o.partial = {8'h00, in_byte_i & u8u16_pkg::LEAD3_MASK};
        state_o.pending = u8u16_pkg::PEND_TWO;
      end
    end else begin
      state_o.pending = state_i.pending - 2'd1;
      state_o.partial = shifted;
      if (state_o.pending == u8u16_pkg::PEND_NONE) begin
        state_o.partial      = '0;
        result_o.valid       = 1'b1;
        result_o.code_unit   = shifted;
        result_o.last_result = string_end_i;
      end
    end
    // string ended inside a sequence
    if (!result_o.valid && string_end_i) begin
      state_o              = '0;
      result_o.valid       = 1'b1;
      result_o.code_unit   = '0;
      result_o.incomplete  = 1'b1;
      result_o.last_result = 1'b1;
    end
  end

endmodule

[design/utf8_to_utf16_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_unit
// Streaming UTF-8 byte to 16-bit code unit decoder.
//
// The input channel (in_valid_i / in_stall_o) carries one byte per
// transaction with string_end_i marking the final byte of a string.
// The output channel (out_valid_o / out_stall_i) carries one code unit per
// completed sequence, with last_result_o on the final result of a string
// and incomplete_o (code unit zero) when a string ends mid-sequence.
// Continuation bytes inside a sequence give no output transaction.
// A byte is taken into an input register, decoded against the sequence
// state combinationally and written to the result register, which drives
// the output. One byte is accepted per cycle while in_stall_o is low; the
// sequence state and result register are the only loop.
// When the receiver stalls, the result register holds its transaction; a
// byte that yields no result still moves on, and in_stall_o rises only when
// the input register holds a result-producing byte that cannot move.
// Reset clears both valid flags and the sequence state.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        string_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        incomplete_o,
  output logic        last_result_o
);

  logic                   in_valid_q;
  logic [7:0]             byte_q;
  logic                   end_q;
  u8u16_pkg::dec_state_t  state_q, state_d;
  u8u16_pkg::dec_result_t res;
  logic                   out_valid_q;
  logic [15:0]            code_unit_q;
  logic                   incomplete_q;
  logic                   last_q;
  logic                   out_free;
  logic                   advance;

  u8u16_dec_core u_core (
    .in_byte_i    (byte_q),
    .string_end_i (end_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .result_o     (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!res.valid || out_free);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= advance && res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= in_byte_i;
      end_q  <= string_end_i;
    end
    if (advance && res.valid) begin
      code_unit_q  <= res.code_unit;
      incomplete_q <= res.incomplete;
      last_q       <= res.last_result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_unit_o   = code_unit_q;
  assign incomplete_o  = incomplete_q;
  assign last_result_o = last_q;

  a_incomplete_fmt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && incomplete_q |-> code_unit_q == 16'h0000 && last_q)
    else $error("incomplete result not zero or not last");

  a_pending_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pending != 2'd3)
    else $error("pending count out of range");

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && res.valid && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  a_end_clears_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && end_q |=> state_q.pending == u8u16_pkg::PEND_NONE)
    else $error("sequence state left open after string end");

endmodule

[tb/sv/tb_utf8_to_utf16_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_stream_decoder_unit
// Self-checking bench for the UTF-8 byte to 16-bit code unit decoder. A short
// table of hand-picked bytes covers ASCII and multi-byte extremes, stray
// continuation leads and strings cut off mid-sequence. Random strings of
// mostly well-formed characters with some noise and truncation follow. Every
// accepted byte runs through a local sequence decoder, and each output
// transaction is compared field by field against the oldest expected unit.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_stream_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES = 850;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned ROW_COUNT    = 23;

  typedef struct packed {
    logic [7:0]             in_byte;
    logic                   str_end;
    logic                   typed;
    u8u16_pkg::dec_result_t want;
  } byte_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        string_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] code_unit_o;
  logic        incomplete_o;
  logic        last_result_o;

  u8u16_pkg::dec_state_t  seq_state = '0;
  u8u16_pkg::dec_result_t expected_units [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  logic        calm = 1'b0;

  byte_row_t directed_rows [ROW_COUNT] = '{
    '{8'h00, 1'b0, 1'b1, '{1'b1, 16'h0000, 1'b0, 1'b0}},
    '{8'h7F, 1'b1, 1'b1, '{1'b1, 16'h007F, 1'b0, 1'b1}},
    '{8'hC3, 1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'hA9, 1'b1, 1'b1, '{1'b1, 16'h00E9, 1'b0, 1'b1}},
    '{8'hE2, 1'b0, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'h82, 1'b0, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'hAC, 1'b1, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'h80, 1'b0, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'hBF, 1'b0, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b1, '{1'b1, 16'hFFFF, 1'b0, 1'b0}},
    '{8'hDF, 1'b0, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'hBF, 1'b1, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'hC2, 1'b1, 1'b1, '{1'b1, 16'h0000, 1'b1, 1'b1}},
    '{8'hE0, 1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'h80, 1'b1, 1'b1, '{1'b1, 16'h0000, 1'b1, 1'b1}},
    '{8'hF0, 1'b0, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'h90, 1'b0, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'h80, 1'b1, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'hED, 1'b0, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'hA0, 1'b0, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}},
    '{8'h80, 1'b1, 1'b0, '{1'b0, 16'h0000, 1'b0, 1'b0}}
  };

  utf8_to_utf16_stream_decoder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .string_end_i  (string_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_unit_o   (code_unit_o),
    .incomplete_o  (incomplete_o),
    .last_result_o (last_result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic u8u16_pkg::dec_result_t decode_byte(input logic [7:0] b,
                                                         input logic str_end);
    u8u16_pkg::dec_result_t unit;
    logic [7:0]             cont;
    unit = '0;
    cont = b & u8u16_pkg::CONT_MASK;
    if (seq_state.pending == u8u16_pkg::PEND_NONE) begin
      if (b < u8u16_pkg::ASCII_LIMIT) begin
        unit.valid = 1'b1;
        unit.code_unit = {8'h00, b};
        unit.last_result = str_end;
        return unit;
      end
      if (b < u8u16_pkg::THREE_BYTE_AT) begin
        seq_state.partial = {8'h00, b & u8u16_pkg::LEAD2_MASK};
        seq_state.pending = u8u16_pkg::PEND_ONE;
      end else begin
        seq_state.partial = {8'h00, b & u8u16_pkg::LEAD3_MASK};
        seq_state.pending = u8u16_pkg::PEND_TWO;
      end
    end else begin
      seq_state.partial = {seq_state.partial[9:0], cont[5:0]};
      seq_state.pending = seq_state.pending - 2'd1;
      if (seq_state.pending == u8u16_pkg::PEND_NONE) begin
        unit.valid = 1'b1;
        unit.code_unit = seq_state.partial;
        unit.last_result = str_end;
        seq_state.partial = '0;
        return unit;
      end
    end
    if (str_end) begin
      seq_state = '0;
      unit.valid = 1'b1;
      unit.incomplete = 1'b1;
      unit.last_result = 1'b1;
    end
    return unit;
  endfunction

  // called at a rising edge, returns at the rising edge that takes the byte
  task automatic send_byte(input logic [7:0] b, input logic str_end, input logic typed,
                           input u8u16_pkg::dec_result_t want);
    u8u16_pkg::dec_result_t unit;
    while (!calm && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    string_end_i <= str_end;
    do @(negedge clk_i); while (in_stall_o);
    unit = decode_byte(b, str_end);
    if (typed) unit = want;
    if (unit.valid) expected_units = {expected_units, unit};
    bytes_sent++;
    calm = (bytes_sent >= 400 && bytes_sent < 560);
    @(posedge clk_i);
  endtask

  task automatic wait_for_units();
    in_valid_i <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_string();
    logic [7:0] str_bytes [$];
    logic [7:0] char_bytes [$];
    int unsigned n_chars;
    int unsigned kind;
    int unsigned n_cont;
    n_chars = $urandom_range(1, 8);
    for (int c = 0; c < n_chars; c++) begin
      char_bytes.delete();
      kind = $urandom_range(99);
      n_cont = 0;
      if (kind < 40) begin
        char_bytes = {char_bytes, 8'($urandom_range(8'h00, 8'h7F))};
      end else if (kind < 65) begin
        char_bytes = {char_bytes, 8'($urandom_range(8'h80, 8'hDF))};
        n_cont = 1;
      end else if (kind < 90) begin
        char_bytes = {char_bytes, 8'($urandom_range(8'hE0, 8'hFF))};
        n_cont = 2;
      end else begin
        char_bytes = {char_bytes, 8'($urandom_range(8'h00, 8'hFF))};
      end
      for (int k = 0; k < n_cont; k++) begin
        if ($urandom_range(9) == 0)
          char_bytes = {char_bytes, 8'($urandom_range(8'h00, 8'hFF))};
        else
          char_bytes = {char_bytes, 8'h80 | 8'($urandom_range(8'h00, 8'h3F))};
      end
      // cut the final character short now and then
      if (c == n_chars - 1 && char_bytes.size() > 1 && $urandom_range(99) < 12)
        char_bytes = char_bytes[0:$urandom_range(0, char_bytes.size() - 2)];
      foreach (char_bytes[k]) str_bytes = {str_bytes, char_bytes[k]};
    end
    foreach (str_bytes[k]) send_byte(str_bytes[k], k == str_bytes.size() - 1, 1'b0, '0);
  endtask

  initial begin
    logic paused;
    paused = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[r])
      send_byte(directed_rows[r].in_byte, directed_rows[r].str_end, directed_rows[r].typed,
                directed_rows[r].want);
    wait_for_units();
    @(posedge clk_i);
    while (bytes_sent < RANDOM_BYTES) begin
      if (!paused && bytes_sent >= 650) begin
        wait_for_units();
        @(posedge clk_i);
        paused = 1'b1;
      end
      send_random_string();
    end
    wait_for_units();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_utf8_to_utf16_stream_decoder_unit: clean");
    end else begin
      $display("tb_utf8_to_utf16_stream_decoder_unit: errors");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 9);
  end

  // output transaction is taken at the next rising edge
  always @(negedge clk_i) begin
    u8u16_pkg::dec_result_t exp_unit;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_units.size() == 0) begin
        $error("unexpected transaction: code_unit %h incomplete %b last_result %b",
               code_unit_o, incomplete_o, last_result_o);
        error_count++;
      end else begin
        exp_unit = expected_units.pop_front();
        if (code_unit_o !== exp_unit.code_unit) begin
          $error("code_unit: expected %h, got %h", exp_unit.code_unit, code_unit_o);
          error_count++;
        end
        if (incomplete_o !== exp_unit.incomplete) begin
          $error("incomplete: expected %b, got %b", exp_unit.incomplete, incomplete_o);
          error_count++;
        end
        if (last_result_o !== exp_unit.last_result) begin
          $error("last_result: expected %b, got %b", exp_unit.last_result, last_result_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_utf8_to_utf16_stream_decoder_unit: errors");
      $finish;
    end
  end

endmodule
